// ===== rtl/sgsd_pkg.sv =====
// Shared types, constants and kernel arithmetic for the smoothing/derivative filter.
`default_nettype none

package sgsd_pkg;

    localparam int KBITS     = 24;
    localparam int COEF_FRAC = 20;
    localparam int OUT_BITS  = 32;
    localparam int OUT_FRAC  = 4;

    typedef enum logic [1:0] {
        K_SMOOTH    = 2'd0,
        K_SLOPE     = 2'd1,
        K_CURVATURE = 2'd2
    } t_kern_sel;

    typedef struct packed {
        logic shift;
        logic clear;
        logic mac_en;
    } t_cell_ctl;

    function automatic logic [63:0] sgsd_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // weight of one tap of the quadratic least-squares fit, on a 2^-20 grid
    function automatic logic signed [KBITS-1:0] sgsd_kern(input int window, input t_kern_sel sel,
                                                          input int tap);
        longint s [5];
        longint x;
        longint xp;
        longint c00, c01, c02, c11, c12, c22;
        longint det;
        longint num;
        longint k0, k1, k2;
        logic [63:0] mag;
        logic [63:0] dd;
        logic [63:0] q;
        logic        neg;
        int          half;
        half = window / 2;
        for (int p = 0; p < 5; p++) s[p] = 0;
        for (int t = 0; t < window; t++) begin
            x  = longint'(t - half);
            xp = 1;
            for (int p = 0; p < 5; p++) begin
                s[p] = s[p] + xp;
                xp   = xp * x;
            end
        end
        c00 = s[2] * s[4] - s[3] * s[3];
        c01 = s[2] * s[3] - s[1] * s[4];
        c02 = s[1] * s[3] - s[2] * s[2];
        c11 = s[0] * s[4] - s[2] * s[2];
        c12 = s[1] * s[2] - s[0] * s[3];
        c22 = s[0] * s[2] - s[1] * s[1];
        det = s[0] * c00 + s[1] * c01 + s[2] * c02;
        case (sel)
            K_SMOOTH: begin
                k0 = c00; k1 = c01; k2 = c02;
            end
            K_SLOPE: begin
                k0 = c01; k1 = c11; k2 = c12;
            end
            default: begin
                k0 = c02; k1 = c12; k2 = c22;
            end
        endcase
        x   = longint'(tap - half);
        num = k0 + k1 * x + k2 * x * x;
        neg = (num < 0);
        mag = neg ? 64'(-num) : 64'(num);
        dd  = 64'(det);
        q   = sgsd_udiv((mag << (COEF_FRAC + 1)) + dd, dd << 1);
        return neg ? KBITS'(-q) : KBITS'(q);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sgsd_if.sv =====
// Valid/ready channel interfaces for samples in and filter results out.
`default_nettype none

interface sgsd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   end_of_record;

    modport source (output valid, output sample, output end_of_record, input ready);
    modport sink   (input valid, input sample, input end_of_record, output ready);
endinterface

interface sgsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] smooth_value;
    logic signed [31:0] slope_value;
    logic signed [31:0] curvature_value;
    logic               last_of_run;
    logic               record_done;

    modport source (output valid, output smooth_value, output slope_value,
                    output curvature_value, output last_of_run, output record_done,
                    input ready);
    modport sink   (input valid, input smooth_value, input slope_value,
                    input curvature_value, input last_of_run, input record_done,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sgsd_cell.sv =====
// One cell of the sample chain: holds a sample and forms its three tap products.
`default_nettype none

module sgsd_cell import sgsd_pkg::*; #(
    parameter int                      SAMPLE_BITS = 24,
    parameter logic signed [KBITS-1:0] K0          = '0,
    parameter logic signed [KBITS-1:0] K1          = '0,
    parameter logic signed [KBITS-1:0] K2          = '0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cell_ctl                           i_ctl,
    input  logic [SAMPLE_BITS-1:0]              i_nb,
    output logic [SAMPLE_BITS-1:0]              o_s,
    output logic signed [SAMPLE_BITS+KBITS:0]   o_p0,
    output logic signed [SAMPLE_BITS+KBITS:0]   o_p1,
    output logic signed [SAMPLE_BITS+KBITS:0]   o_p2
);
    localparam int PW = SAMPLE_BITS + 1 + KBITS;

    logic [SAMPLE_BITS-1:0] r_s;
    logic signed [PW-1:0]   r_p0;
    logic signed [PW-1:0]   r_p1;
    logic signed [PW-1:0]   r_p2;
    logic signed [SAMPLE_BITS:0] w_x;

    assign w_x = $signed({1'b0, r_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (i_ctl.shift) begin
            r_s <= i_nb;
        end else if (i_ctl.clear) begin
            r_s <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_en) begin
            r_p0 <= PW'(w_x * K0);
            r_p1 <= PW'(w_x * K1);
            r_p2 <= PW'(w_x * K2);
        end
    end

    assign o_s  = r_s;
    assign o_p0 = r_p0;
    assign o_p1 = r_p1;
    assign o_p2 = r_p2;

endmodule

`default_nettype wire

// ===== rtl/sgsd_tree.sv =====
// Registered pairwise adder tree over the tap products of one kernel.
`default_nettype none

module sgsd_tree import sgsd_pkg::*; #(
    parameter int N  = 11,
    parameter int IW = 49,
    parameter int OW = 53
) (
    input  logic                      i_clk,
    input  logic [$clog2(N)-1:0]      i_en,
    input  logic signed [IW-1:0]      i_leaf [N],
    output logic signed [OW-1:0]      o_sum
);
    localparam int LEV = $clog2(N);
    localparam int HN  = (N + 1) / 2;

    logic signed [OW-1:0] w_src  [LEV][2*HN];
    logic signed [OW-1:0] r_node [LEV][HN];

    always_comb begin
        for (int i = 0; i < 2 * HN; i++) begin
            w_src[0][i] = (i < N) ? OW'(i_leaf[(i < N) ? i : 0]) : '0;
        end
        for (int l = 1; l < LEV; l++) begin
            for (int i = 0; i < 2 * HN; i++) begin
                w_src[l][i] = (i < ((N + (1 << l) - 1) >> l))
                              ? r_node[l-1][(i < HN) ? i : 0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LEV; k++) begin
            if (i_en[k]) begin
                for (int i = 0; i < HN; i++) begin
                    r_node[k][i] <= w_src[k][2*i] + w_src[k][2*i+1];
                end
            end
        end
    end

    assign o_sum = r_node[LEV-1][0];

endmodule

`default_nettype wire

// ===== rtl/savitzky_golay_smooth_derivs.sv =====
// Quadratic least-squares smoothing filter with slope and curvature outputs.
// Takes one sample per cycle in steady state while the output is not stalled,
// and gives one result for it, the result lagging WINDOW/2 samples behind.
// Nothing comes out until WINDOW samples of a record have arrived; that sample
// then releases WINDOW-WINDOW/2 results, and the end-of-record sample releases
// WINDOW/2 more (a record shorter than WINDOW releases all its samples
// unfiltered); during such a burst the input is held off, and results issue one
// per cycle while the output is not stalled, the sample chain stepping once per
// result. From accept to result a sample passes the chain entry, one product
// stage, the adder tree levels and one rounding stage. Results saturate to
// signed 32 bits with 4 fractional bits.
`default_nettype none

module savitzky_golay_smooth_derivs import sgsd_pkg::*; #(
    parameter int WINDOW      = 11,
    parameter int SAMPLE_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sgsd_in_if.sink           i_in,
    sgsd_out_if.source        o_out
);
    localparam int  HALF  = WINDOW / 2;
    localparam int  L     = WINDOW + HALF;
    localparam int  ENTRY = 2 * HALF;
    localparam bit  EVEN  = (WINDOW % 2) == 0;
    localparam int  CW    = $clog2(WINDOW + 1);
    localparam int  IW    = $clog2(L);
    localparam int  LEV   = $clog2(WINDOW);
    localparam int  S     = LEV + 2;
    localparam int  PW    = SAMPLE_BITS + 1 + KBITS;
    localparam int  AW    = PW + LEV;

    t_cell_ctl                w_ctl;
    logic [SAMPLE_BITS-1:0]   w_s   [L];
    logic [SAMPLE_BITS-1:0]   w_nb  [L];
    logic signed [PW-1:0]     w_p0  [WINDOW];
    logic signed [PW-1:0]     w_p1  [WINDOW];
    logic signed [PW-1:0]     w_p2  [WINDOW];
    logic signed [AW-1:0]     w_sum0;
    logic signed [AW-1:0]     w_sum1;
    logic signed [AW-1:0]     w_sum2;

    logic [CW-1:0]            r_cnt,  n_cnt;
    logic [CW-1:0]            r_pend, n_pend;
    logic                     r_rawrun, n_rawrun;
    logic                     r_eor,  n_eor;
    logic [IW-1:0]            r_ridx, n_ridx;

    logic [S:0]               w_en;
    logic                     w_acc;
    logic                     w_issue;
    logic                     w_clear;
    logic                     w_fill_acc;
    logic                     w_steady_acc;
    logic [CW-1:0]            w_base;
    logic [CW-1:0]            w_nc;

    logic                     r_v    [S];
    logic                     r_last [S];
    logic                     r_done [S];
    logic                     r_raw  [S];
    logic [SAMPLE_BITS-1:0]   r_rv   [S];
    logic signed [31:0]       r_sm;
    logic signed [31:0]       r_sl;
    logic signed [31:0]       r_cv;
    logic signed [31:0]       n_sm;
    logic signed [31:0]       n_sl;
    logic signed [31:0]       n_cv;

    function automatic logic signed [31:0] f_round(input logic signed [AW-1:0] acc);
        logic signed [AW:0]  sum;
        logic signed [63:0]  q;
        sum = (AW+1)'(acc) + (AW+1)'(1 << 15);
        q   = 64'(sum) >>> 16;
        if (q > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (q < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(q);
    endfunction

    // chain of sample cells
    for (genvar t = 0; t < L; t++) begin : g_cell
        localparam logic signed [KBITS-1:0] K0 =
            (t < WINDOW) ? sgsd_kern(WINDOW, K_SMOOTH, t) : '0;
        localparam logic signed [KBITS-1:0] K1 =
            (t < WINDOW) ? sgsd_kern(WINDOW, K_SLOPE, t) : '0;
        localparam logic signed [KBITS-1:0] K2 =
            (t < WINDOW) ? sgsd_kern(WINDOW, K_CURVATURE, t) : '0;
        if (t < WINDOW) begin : g_mac
            sgsd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .K0          (K0),
                .K1          (K1),
                .K2          (K2)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_nb    (w_nb[t]),
                .o_s     (w_s[t]),
                .o_p0    (w_p0[t]),
                .o_p1    (w_p1[t]),
                .o_p2    (w_p2[t])
            );
        end else begin : g_tail
            sgsd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_nb    (w_nb[t]),
                .o_s     (w_s[t]),
                .o_p0    (),
                .o_p1    (),
                .o_p2    ()
            );
        end
    end

    sgsd_tree #(.N(WINDOW), .IW(PW), .OW(AW)) u_tree0 (
        .i_clk (i_clk), .i_en (w_en[LEV:1]), .i_leaf (w_p0), .o_sum (w_sum0)
    );
    sgsd_tree #(.N(WINDOW), .IW(PW), .OW(AW)) u_tree1 (
        .i_clk (i_clk), .i_en (w_en[LEV:1]), .i_leaf (w_p1), .o_sum (w_sum1)
    );
    sgsd_tree #(.N(WINDOW), .IW(PW), .OW(AW)) u_tree2 (
        .i_clk (i_clk), .i_en (w_en[LEV:1]), .i_leaf (w_p2), .o_sum (w_sum2)
    );

    // stage enables, output side first
    always_comb begin
        w_en[S] = o_out.ready;
        for (int k = S - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_issue = (r_pend != '0) && w_en[0];
    assign w_clear = w_issue && (r_pend == CW'(1)) && r_eor;
    assign i_in.ready = w_en[0] && (r_pend <= CW'(1));
    assign w_acc = i_in.valid && i_in.ready;
    assign w_base = w_clear ? '0 : r_cnt;
    assign w_nc = (w_base < CW'(WINDOW)) ? w_base + CW'(1) : CW'(WINDOW);
    assign w_fill_acc = w_acc && (w_base < CW'(WINDOW));
    assign w_steady_acc = w_acc && (w_base == CW'(WINDOW));

    assign w_ctl = '{shift:  w_acc || (w_issue && (r_pend > CW'(1))),
                     clear:  w_clear,
                     mac_en: w_en[0]};

    always_comb begin
        for (int t = 0; t < L; t++) begin
            w_nb[t] = (t < L - 1 && !w_clear) ? w_s[(t < L - 1) ? t + 1 : 0] : '0;
            if (t == ENTRY && w_steady_acc) begin
                w_nb[t] = i_in.sample;
            end
            if (t == L - 1 && w_fill_acc) begin
                w_nb[t] = i_in.sample;
            end
            if (t == 0 && EVEN && w_steady_acc) begin
                w_nb[t] = '0;
            end
        end
    end

    always_comb begin
        n_cnt    = w_clear ? '0 : r_cnt;
        n_pend   = w_issue ? r_pend - CW'(1) : r_pend;
        n_rawrun = r_rawrun;
        n_eor    = r_eor;
        n_ridx   = r_ridx;
        if (w_acc) begin
            n_cnt = w_nc;
            n_eor = i_in.end_of_record;
            if (w_nc < CW'(WINDOW)) begin
                n_rawrun = 1'b1;
                n_pend   = i_in.end_of_record ? w_nc : '0;
                n_ridx   = IW'(L) - IW'(w_nc);
            end else begin
                n_rawrun = 1'b0;
                n_pend   = ((w_base < CW'(WINDOW)) ? CW'(WINDOW - HALF) : CW'(1))
                         + (i_in.end_of_record ? CW'(HALF) : CW'(0));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pend   <= '0;
            r_rawrun <= 1'b0;
            r_eor    <= 1'b0;
            r_ridx   <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_rawrun <= n_rawrun;
            r_eor    <= n_eor;
            r_ridx   <= n_ridx;
        end
    end

    // round and saturate the tree sums, or scale and saturate a raw sample
    always_comb begin
        logic [63:0] rv;
        rv = 64'(r_rv[S-2]) << OUT_FRAC;
        if (r_raw[S-2]) begin
            n_sm = (|rv[63:31]) ? 32'sh7fffffff : $signed(rv[31:0]);
            n_sl = '0;
            n_cv = '0;
        end else begin
            n_sm = f_round(w_sum0);
            n_sl = f_round(w_sum1);
            n_cv = f_round(w_sum2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) r_v[k] <= 1'b0;
        end else begin
            for (int k = 0; k < S; k++) begin
                if (w_en[k]) begin
                    if (k == 0) begin
                        r_v[k]    <= w_issue;
                        r_last[k] <= (r_pend == CW'(1));
                        r_done[k] <= (r_pend == CW'(1)) && r_eor;
                        r_raw[k]  <= r_rawrun;
                        r_rv[k]   <= w_s[r_ridx];
                    end else begin
                        r_v[k]    <= r_v[k-1];
                        r_last[k] <= r_last[k-1];
                        r_done[k] <= r_done[k-1];
                        r_raw[k]  <= r_raw[k-1];
                        r_rv[k]   <= r_rv[k-1];
                    end
                end
            end
            if (w_en[S-1]) begin
                r_sm <= n_sm;
                r_sl <= n_sl;
                r_cv <= n_cv;
            end
        end
    end

    assign o_out.valid           = r_v[S-1];
    assign o_out.smooth_value    = r_sm;
    assign o_out.slope_value     = r_sl;
    assign o_out.curvature_value = r_cv;
    assign o_out.last_of_run     = r_last[S-1];
    assign o_out.record_done     = r_done[S-1];

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clear && !w_acc) |=> (r_cnt == '0))
        else $error("sample count not cleared at end of record");

    a_eor_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.end_of_record) |=> (r_pend != '0))
        else $error("end of record released no results");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CW'(WINDOW))
        else $error("pending result count out of range");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.record_done) |-> o_out.last_of_run)
        else $error("record end without run end");

endmodule

`default_nettype wire
